>>> rtl/core/forwarding_table_lookup_defines.svh
// Assertion helpers for the forwarding table lookup block.
`ifndef FORWARDING_TABLE_LOOKUP_DEFINES_SVH
`define FORWARDING_TABLE_LOOKUP_DEFINES_SVH

// Clocked check, quiet while reset is asserted.
`define FTL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define FTL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/fwd_pkg.sv
package fwd_pkg;

  localparam int unsigned TableDepthDefault = 16;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned HOP_W      = 8;
  localparam int unsigned DLY_W      = 16;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_HOP   = 1'b0,
    CFG_DEFAULT_DELAY = 1'b1
  } cfg_reg_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_HIT       = 3'd1,
    ST_DEFAULT   = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic start;   // latch the new item, rewind the scan
    logic issue;   // read the next table entry
    logic finish;  // commit the item and load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;       // insert into a full table
    logic hit;        // registered entry matches the key
    logic exhausted;  // every filled entry has been read
    logic rd_vld;     // read data register holds an entry
  } sts_t;

endpackage

>>> rtl/core/fwd_ifs.sv
interface fwd_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [fwd_pkg::ADDR_W-1:0]   address;
  logic [fwd_pkg::HOP_W-1:0]    next_hop;
  logic [fwd_pkg::DLY_W-1:0]    delay;

  modport source (output valid, kind, address, next_hop, delay, input ready);
  modport sink   (input valid, kind, address, next_hop, delay, output ready);
endinterface

interface fwd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fwd_pkg::HOP_W-1:0]     hop_out;
  logic [fwd_pkg::DLY_W-1:0]     delay_out;
  logic [fwd_pkg::STAT_W-1:0]    status;
  logic [fwd_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, hop_out, delay_out, status, entry_count, input ready);
  modport sink   (input valid, hop_out, delay_out, status, entry_count, output ready);
endinterface

>>> rtl/core/forwarding_table_lookup.sv
// An insert into a full table, or any item on an empty table, resolves without a scan; a lookup
//   or duplicate hit stops the scan at its slot, and a miss or insert reads every filled entry.
// One item at a time: a new item is taken only once the last has finished, and the scan
//   reads one table entry per cycle through the single read port of the entry memory.
// Reset (rst_ni, async, active low) empties the table and zeroes the default route;
//   entry memories are not cleared, an entry is only read once filled.
`include "forwarding_table_lookup_defines.svh"

module forwarding_table_lookup #(
  parameter int unsigned TableDepth = fwd_pkg::TableDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fwd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fwd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fwd_req_if.sink                        req_i,
  fwd_rsp_if.source                      rsp_o
);

  fwd_pkg::cmd_t cmd;
  fwd_pkg::sts_t sts;

  // Controller: accepts a beat in idle, steps the scan, and owns the result valid.
  // A finished result waits in the output register while the next beat is taken.
  fwd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: entry memories, scan index, compare against the registered entry,
  // fill count, default route and the result register.
  fwd_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (req_i.kind),
    .address_i     (req_i.address),
    .next_hop_i    (req_i.next_hop),
    .delay_i       (req_i.delay),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .hop_out_o     (rsp_o.hop_out),
    .delay_out_o   (rsp_o.delay_out),
    .status_o      (rsp_o.status),
    .entry_count_o (rsp_o.entry_count)
  );

  // A finished item always shows up as a result beat in the next cycle.
  `FTL_ASSERT(a_finish_shows, clk_i, rst_ni, cmd.finish |=> rsp_o.valid, "finish without result")

  // One item in flight: no second beat is taken right after an accepted one.
  `FTL_ASSERT(a_one_item, clk_i, rst_ni, (req_i.valid && req_i.ready) |=> !req_i.ready, "overlapping items")

  // The scan stops reading once the item has resolved.
  `FTL_ASSERT_ALWAYS(a_no_read_at_finish, clk_i, !(cmd.issue && cmd.finish), "read while finishing")

  // A refused insert into a full table carries no route.
  `FTL_ASSERT(a_full_zero, clk_i, rst_ni, (rsp_o.valid && rsp_o.status == fwd_pkg::ST_FULL) |-> (rsp_o.hop_out == '0 && rsp_o.delay_out == '0), "full status with route data")

endmodule

>>> rtl/core/fwd_ctrl.sv
module fwd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fwd_pkg::sts_t sts_i,
  output fwd_pkg::cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   done_cond;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Search ends on full table, on a match, or once the last read has drained.
  assign done_cond = sts_i.full || sts_i.hit || (sts_i.exhausted && !sts_i.rd_vld);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = (out_valid_q && !out_ready_i);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.issue = !sts_i.full && !sts_i.hit && !sts_i.exhausted;
        if (done_cond && out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/fwd_dp.sv
module fwd_dp #(
  parameter int unsigned TableDepth = fwd_pkg::TableDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fwd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fwd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              kind_i,
  input  logic [fwd_pkg::ADDR_W-1:0]        address_i,
  input  logic [fwd_pkg::HOP_W-1:0]         next_hop_i,
  input  logic [fwd_pkg::DLY_W-1:0]         delay_i,
  input  fwd_pkg::cmd_t                     cmd_i,
  output fwd_pkg::sts_t                     sts_o,
  output logic [fwd_pkg::HOP_W-1:0]         hop_out_o,
  output logic [fwd_pkg::DLY_W-1:0]         delay_out_o,
  output logic [fwd_pkg::STAT_W-1:0]        status_o,
  output logic [fwd_pkg::COUNT_W-1:0]       entry_count_o
);

  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  // Table storage, one entry read per cycle.
  logic [fwd_pkg::ADDR_W-1:0] addr_mem [TableDepth];
  logic [fwd_pkg::HOP_W-1:0]  hop_mem  [TableDepth];
  logic [fwd_pkg::DLY_W-1:0]  dly_mem  [TableDepth];

  logic [fwd_pkg::HOP_W-1:0]  dflt_hop_q;
  logic [fwd_pkg::DLY_W-1:0]  dflt_dly_q;

  logic                       kind_q;
  logic [fwd_pkg::ADDR_W-1:0] key_q;
  logic [fwd_pkg::HOP_W-1:0]  new_hop_q;
  logic [fwd_pkg::DLY_W-1:0]  new_dly_q;

  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [CntW-1:0]            idx_q;
  logic                       rd_vld_q;
  logic [fwd_pkg::ADDR_W-1:0] rd_addr_q;
  logic [fwd_pkg::HOP_W-1:0]  rd_hop_q;
  logic [fwd_pkg::DLY_W-1:0]  rd_dly_q;

  logic [fwd_pkg::HOP_W-1:0]  res_hop_q;
  logic [fwd_pkg::DLY_W-1:0]  res_dly_q;
  fwd_pkg::status_e           res_status_q;
  logic [fwd_pkg::COUNT_W-1:0] res_count_q;

  logic                       full;
  logic                       hit;
  logic                       ins_ok;
  fwd_pkg::status_e           status_d;
  logic [fwd_pkg::HOP_W-1:0]  hop_d;
  logic [fwd_pkg::DLY_W-1:0]  dly_d;

  assign full   = (kind_q == fwd_pkg::KIND_INSERT) && (cnt_q == CntW'(TableDepth));
  assign hit    = rd_vld_q && (rd_addr_q == key_q);
  assign ins_ok = (kind_q == fwd_pkg::KIND_INSERT) && !full && !hit;

  assign sts_o.full      = full;
  assign sts_o.hit       = hit;
  assign sts_o.exhausted = (idx_q == cnt_q);
  assign sts_o.rd_vld    = rd_vld_q;

  assign cnt_d = cnt_q + CntW'(cmd_i.finish && ins_ok);

  always_comb begin
    hop_d = '0;
    dly_d = '0;
    if (full) begin
      status_d = fwd_pkg::ST_FULL;
    end else if (kind_q == fwd_pkg::KIND_INSERT) begin
      status_d = hit ? fwd_pkg::ST_DUPLICATE : fwd_pkg::ST_INSERTED;
    end else if (hit) begin
      status_d = fwd_pkg::ST_HIT;
      hop_d    = rd_hop_q;
      dly_d    = rd_dly_q;
    end else begin
      status_d = fwd_pkg::ST_DEFAULT;
      hop_d    = dflt_hop_q;
      dly_d    = dflt_dly_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      idx_q      <= '0;
      rd_vld_q   <= 1'b0;
      dflt_hop_q <= '0;
      dflt_dly_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.start) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.issue) begin
        idx_q    <= idx_q + CntW'(1);
        rd_vld_q <= 1'b1;
      end else if (!hit) begin
        rd_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (fwd_pkg::cfg_reg_e'(cfg_idx_i))
          fwd_pkg::CFG_DEFAULT_HOP:   dflt_hop_q <= cfg_data_i[fwd_pkg::HOP_W-1:0];
          fwd_pkg::CFG_DEFAULT_DELAY: dflt_dly_q <= cfg_data_i[fwd_pkg::DLY_W-1:0];
        endcase
      end
    end
  end

  // Item, read data, result and table contents.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q    <= kind_i;
      key_q     <= address_i;
      new_hop_q <= next_hop_i;
      new_dly_q <= delay_i;
    end
    if (cmd_i.issue) begin
      rd_addr_q <= addr_mem[idx_q[IdxW-1:0]];
      rd_hop_q  <= hop_mem[idx_q[IdxW-1:0]];
      rd_dly_q  <= dly_mem[idx_q[IdxW-1:0]];
    end
    if (cmd_i.finish) begin
      res_hop_q    <= hop_d;
      res_dly_q    <= dly_d;
      res_status_q <= status_d;
      res_count_q  <= fwd_pkg::COUNT_W'(cnt_d);
      if (ins_ok) begin
        addr_mem[cnt_q[IdxW-1:0]] <= key_q;
        hop_mem[cnt_q[IdxW-1:0]]  <= new_hop_q;
        dly_mem[cnt_q[IdxW-1:0]]  <= new_dly_q;
      end
    end
  end

  assign hop_out_o     = res_hop_q;
  assign delay_out_o   = res_dly_q;
  assign status_o      = res_status_q;
  assign entry_count_o = res_count_q;

endmodule
